/* hdl/tpx_pkg.sv */
// ----------------------------------------------------------------------------
// tpx_pkg
// shared constants and types of the tree path xor pair counter
// ----------------------------------------------------------------------------
package tpx_pkg;

   localparam int MAX_NODES_DEFAULT   = 1024;
   localparam int WEIGHT_BITS_DEFAULT = 32;

   localparam int NODE_FIELD_BITS   = 10;
   localparam int WEIGHT_FIELD_BITS = 32;
   localparam int COUNT_BITS        = 19;
   localparam int TARGET_BITS       = 32;
   localparam int NODE_COUNT_BITS   = 11;
   localparam int CSR_DATA_BITS     = 32;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int REQ_DATA_BITS     = 56;
   localparam int RSP_DATA_BITS     = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_XOR = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NODE_COUNT = 1'b1;

   localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 11'd2;

   typedef struct packed {
      logic                  valid;
      logic [COUNT_BITS-1:0] count;
   } res_type;

   typedef struct packed {
      logic idle;
      logic clearing;
   } stat_type;

endpackage

/* hdl/tpx_ram.sv */
// ----------------------------------------------------------------------------
// tpx_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tpx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/tpx_core.sv */
// ----------------------------------------------------------------------------
// tpx_core
// edge store loading, breadth-first walk and pair count over three rams
// ----------------------------------------------------------------------------
module tpx_core #(
   parameter int MAX_NODES   = tpx_pkg::MAX_NODES_DEFAULT,
   parameter int WEIGHT_BITS = tpx_pkg::WEIGHT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [tpx_pkg::TARGET_BITS-1:0]       target_xor,
   input  logic [tpx_pkg::NODE_COUNT_BITS-1:0]   node_count,
   input  logic                                  in_valid,
   input  logic [tpx_pkg::NODE_FIELD_BITS-1:0]   in_from,
   input  logic [tpx_pkg::NODE_FIELD_BITS-1:0]   in_to,
   input  logic [tpx_pkg::WEIGHT_FIELD_BITS-1:0] in_weight,
   input  logic                                  in_last,
   input  logic                                  slot_free,
   output tpx_pkg::stat_type                     stat,
   output tpx_pkg::res_type                      res
);

   localparam int NB = $clog2(MAX_NODES);
   localparam int EDGE_DEPTH = 2 * MAX_NODES;
   localparam int EB = NB + 1;
   localparam int PB = EB + 1;
   localparam int WB = WEIGHT_BITS;
   localparam int CB = tpx_pkg::COUNT_BITS;
   localparam logic [PB-1:0] EMPTY_MARK = {1'b1, EB'(0)};
   localparam int ND_W = PB + 1;
   localparam int ED_W = NB + WB + PB;
   localparam int Q_W  = NB + WB;

   typedef enum logic [14:0] {
      S_IDLE = 15'b000000000000001,
      S_LD_B = 15'b000000000000010,
      S_LD_C = 15'b000000000000100,
      S_INIT = 15'b000000000001000,
      S_INI2 = 15'b000000000010000,
      S_POP  = 15'b000000000100000,
      S_POPW = 15'b000000001000000,
      S_HEAD = 15'b000000010000000,
      S_EDGE = 15'b000000100000000,
      S_CHK  = 15'b000001000000000,
      S_CI   = 15'b000010000000000,
      S_CA   = 15'b000100000000000,
      S_CJ   = 15'b001000000000000,
      S_OUT  = 15'b010000000000000,
      S_CLR  = 15'b100000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [NB-1:0]     a_ff, a_in, b_ff, b_in;
   logic [WB-1:0]     w_ff, w_in;
   logic              ok_ff, ok_in, last_ff, last_in;
   logic [EB:0]       fill_ff, fill_in;
   logic [NB:0]       front_ff, front_in, back_ff, back_in;
   logic [NB:0]       i_ff, i_in, j_ff, j_in;
   logic [WB-1:0]     xv_ff, xv_in, ax_ff, ax_in;
   logic [NB-1:0]     cu_ff, cu_in;
   logic [WB-1:0]     cw_ff, cw_in;
   logic [PB-1:0]     cl_ff, cl_in;
   logic [CB-1:0]     cnt_ff, cnt_in;
   logic [NB-1:0]     clr_ff, clr_in;

   logic [NB:0]       n_eff;
   logic              nd_we, ed_we, q_we;
   logic [NB-1:0]     nd_waddr, nd_raddr, q_waddr, q_raddr;
   logic [EB-1:0]     ed_waddr, ed_raddr;
   logic [ND_W-1:0]   nd_wdata, nd_rdata;
   logic [ED_W-1:0]   ed_wdata, ed_rdata;
   logic [Q_W-1:0]    q_wdata, q_rdata;
   logic              res_valid;

   tpx_ram #(.WIDTH(ND_W), .DEPTH(MAX_NODES)) u_node (
      .clock(clock), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
      .raddr(nd_raddr), .rdata(nd_rdata)
   );

   tpx_ram #(.WIDTH(ED_W), .DEPTH(EDGE_DEPTH)) u_edge (
      .clock(clock), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
      .raddr(ed_raddr), .rdata(ed_rdata)
   );

   tpx_ram #(.WIDTH(Q_W), .DEPTH(MAX_NODES)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata)
   );

   always_comb begin
      if (32'(node_count) > 32'(MAX_NODES)) begin
         n_eff = (NB+1)'(MAX_NODES);
      end else begin
         n_eff = (NB+1)'(node_count);
      end
   end

   always_comb begin
      logic [PB-1:0] head_b;
      logic [PB-1:0] link;
      logic [NB-1:0] eu;
      state_in = state_ff;
      a_in = a_ff;  b_in = b_ff;  w_in = w_ff;
      ok_in = ok_ff;  last_in = last_ff;
      fill_in = fill_ff;
      front_in = front_ff;  back_in = back_ff;
      i_in = i_ff;  j_in = j_ff;
      xv_in = xv_ff;  ax_in = ax_ff;
      cu_in = cu_ff;  cw_in = cw_ff;  cl_in = cl_ff;
      cnt_in = cnt_ff;  clr_in = clr_ff;
      nd_we = 1'b0;  nd_waddr = '0;  nd_wdata = '0;  nd_raddr = '0;
      ed_we = 1'b0;  ed_waddr = '0;  ed_wdata = '0;  ed_raddr = '0;
      q_we = 1'b0;   q_waddr = '0;   q_wdata = '0;   q_raddr = '0;
      res_valid = 1'b0;
      head_b = '0;
      link = '0;
      eu = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               a_in = NB'(in_from);
               b_in = NB'(in_to);
               w_in = in_weight[WB-1:0];
               last_in = in_last;
               ok_in = (32'(in_from) < 32'(n_eff)) && (32'(in_to) < 32'(n_eff)) &&
                       (32'(fill_ff) + 32'd2 <= 32'(EDGE_DEPTH));
               nd_raddr = NB'(in_from);
               state_in = S_LD_B;
            end
         end
         S_LD_B: begin
            if (ok_ff) begin
               ed_we = 1'b1;
               ed_waddr = fill_ff[EB-1:0];
               ed_wdata = {b_ff, w_ff, nd_rdata[PB-1:0]};
               nd_we = 1'b1;
               nd_waddr = a_ff;
               nd_wdata = {1'b0, PB'(fill_ff)};
            end
            nd_raddr = b_ff;
            state_in = S_LD_C;
         end
         S_LD_C: begin
            head_b = (a_ff == b_ff) ? PB'(fill_ff) : nd_rdata[PB-1:0];
            if (ok_ff) begin
               ed_we = 1'b1;
               ed_waddr = EB'(fill_ff + 1'b1);
               ed_wdata = {a_ff, w_ff, head_b};
               nd_we = 1'b1;
               nd_waddr = b_ff;
               nd_wdata = {1'b0, PB'(fill_ff + 1'b1)};
               fill_in = fill_ff + 2'd2;
            end
            state_in = last_ff ? S_INIT : S_IDLE;
         end
         S_INIT: begin
            cnt_in = '0;
            nd_raddr = '0;
            if (n_eff == '0) begin
               state_in = S_OUT;
            end else begin
               state_in = S_INI2;
            end
         end
         S_INI2: begin
            nd_we = 1'b1;
            nd_waddr = '0;
            nd_wdata = {1'b1, nd_rdata[PB-1:0]};
            q_we = 1'b1;
            q_waddr = '0;
            q_wdata = '0;
            front_in = '0;
            back_in = (NB+1)'(1);
            state_in = S_POP;
         end
         S_POP: begin
            if (front_ff < back_ff) begin
               q_raddr = front_ff[NB-1:0];
               front_in = front_ff + 1'b1;
               state_in = S_POPW;
            end else begin
               i_in = '0;
               state_in = S_CI;
            end
         end
         S_POPW: begin
            xv_in = q_rdata[WB-1:0];
            nd_raddr = q_rdata[Q_W-1 -: NB];
            state_in = S_HEAD;
         end
         S_HEAD: begin
            if (nd_rdata[PB-1]) begin
               state_in = S_POP;
            end else begin
               ed_raddr = nd_rdata[EB-1:0];
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            eu = ed_rdata[ED_W-1 -: NB];
            link = ed_rdata[PB-1:0];
            cu_in = eu;
            cw_in = ed_rdata[PB +: WB];
            cl_in = link;
            if ((32'(eu) < 32'(n_eff)) && (back_ff < n_eff)) begin
               nd_raddr = eu;
               state_in = S_CHK;
            end else if (link[PB-1]) begin
               state_in = S_POP;
            end else begin
               ed_raddr = link[EB-1:0];
            end
         end
         S_CHK: begin
            if (!nd_rdata[ND_W-1]) begin
               nd_we = 1'b1;
               nd_waddr = cu_ff;
               nd_wdata = {1'b1, nd_rdata[PB-1:0]};
               q_we = 1'b1;
               q_waddr = back_ff[NB-1:0];
               q_wdata = {cu_ff, xv_ff ^ cw_ff};
               back_in = back_ff + 1'b1;
            end
            if (cl_ff[PB-1]) begin
               state_in = S_POP;
            end else begin
               ed_raddr = cl_ff[EB-1:0];
               state_in = S_EDGE;
            end
         end
         S_CI: begin
            if (32'(i_ff) + 32'd1 >= 32'(back_ff)) begin
               state_in = S_OUT;
            end else begin
               q_raddr = i_ff[NB-1:0];
               state_in = S_CA;
            end
         end
         S_CA: begin
            ax_in = q_rdata[WB-1:0];
            j_in = i_ff + 1'b1;
            q_raddr = NB'(i_ff + 1'b1);
            state_in = S_CJ;
         end
         S_CJ: begin
            if (32'(ax_ff ^ q_rdata[WB-1:0]) == target_xor) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (32'(j_ff) + 32'd1 < 32'(back_ff)) begin
               q_raddr = NB'(j_ff + 1'b1);
               j_in = j_ff + 1'b1;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_CI;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               res_valid = 1'b1;
               clr_in = '0;
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            nd_we = 1'b1;
            nd_waddr = clr_ff;
            nd_wdata = {1'b0, EMPTY_MARK};
            clr_in = clr_ff + 1'b1;
            fill_in = '0;
            if (32'(clr_ff) == 32'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         fill_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         fill_ff <= fill_in;
      end
      a_ff <= a_in;  b_ff <= b_in;  w_ff <= w_in;
      ok_ff <= ok_in;  last_ff <= last_in;
      front_ff <= front_in;  back_ff <= back_in;
      i_ff <= i_in;  j_ff <= j_in;
      xv_ff <= xv_in;  ax_ff <= ax_in;
      cu_ff <= cu_in;  cw_ff <= cw_in;  cl_ff <= cl_in;
      cnt_ff <= cnt_in;
   end

   assign stat.idle     = (state_ff == S_IDLE);
   assign stat.clearing = (state_ff == S_CLR);
   assign res.valid     = res_valid;
   assign res.count     = cnt_ff;

endmodule

/* hdl/tree_path_xor_pair_count_top.sv */
// ----------------------------------------------------------------------------
// tree_path_xor_pair_count_top
// loads a weighted tree edge by edge, then counts node pairs by path xor
// ----------------------------------------------------------------------------
// Each edge item passes S_IDLE, S_LD_B and S_LD_C (two head reads and two
// linked-list inserts through the write port of the node ram). After the item
// marked last, the walk pops the queue and follows each stored edge end, and
// the pair count compares every pair of the R reached nodes, one queue ram
// read per pair. The count item is then followed by a clearing pass over
// every node ram entry, during which no item is taken; the same pass runs
// once after reset.
module tree_path_xor_pair_count_top #(
   parameter int MAX_NODES   = tpx_pkg::MAX_NODES_DEFAULT,
   parameter int WEIGHT_BITS = tpx_pkg::WEIGHT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // from_node [9:0], to_node [19:10], weight [51:20], zero fill
   input  logic [tpx_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pair_count [18:0], zero fill
   output logic [tpx_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic                                 csr_we,
   input  logic [tpx_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tpx_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int NF = tpx_pkg::NODE_FIELD_BITS;

   logic [tpx_pkg::TARGET_BITS-1:0]     target_ff, target_in;
   logic [tpx_pkg::NODE_COUNT_BITS-1:0] nodes_ff, nodes_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tpx_pkg::COUNT_BITS-1:0]      rsp_count_ff, rsp_count_in;
   tpx_pkg::stat_type                   stat;
   tpx_pkg::res_type                    res;
   logic                                slot_free;

   always_comb begin
      target_in = target_ff;
      nodes_in = nodes_ff;
      if (csr_we) begin
         case (csr_index)
            tpx_pkg::CSR_TARGET_XOR: target_in = csr_wdata;
            tpx_pkg::CSR_NODE_COUNT: nodes_in = csr_wdata[tpx_pkg::NODE_COUNT_BITS-1:0];
            default: target_in = target_ff;
         endcase
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = res.count;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         nodes_ff <= tpx_pkg::NODE_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff <= target_in;
         nodes_ff <= nodes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
   end

   tpx_core #(.MAX_NODES(MAX_NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .target_xor (target_ff),
      .node_count (nodes_ff),
      .in_valid   (req_tvalid),
      .in_from    (req_tdata[NF-1:0]),
      .in_to      (req_tdata[2*NF-1:NF]),
      .in_weight  (req_tdata[2*NF +: tpx_pkg::WEIGHT_FIELD_BITS]),
      .in_last    (req_tlast),
      .slot_free  (slot_free),
      .stat       (stat),
      .res        (res)
   );

   assign req_tready = stat.idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tpx_pkg::RSP_DATA_BITS - tpx_pkg::COUNT_BITS){1'b0}}, rsp_count_ff};

   // a new count never lands on a waiting one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (!rsp_valid_ff || rsp_tready))
      else $error("count overwrote a waiting item");

   // an accepted edge never yields a count in the next cycle
   a_no_early_count: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !res.valid)
      else $error("count issued too early");

   // every count is followed by the clearing pass
   a_clear_after_count: assert property (@(posedge clock) disable iff (reset)
      res.valid |=> stat.clearing)
      else $error("clearing pass missing after count");

   // no edge is taken while the node ram is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !req_tready)
      else $error("item accepted during clearing pass");

endmodule

/* verif/tree_path_xor_pair_count_top_test.sv */
// ----------------------------------------------------------------------------
// tree_path_xor_pair_count_top_test
// self-checking bench for the tree path xor pair counter: loads trees edge by
// edge under varied node counts and targets, predicts pair counts with its
// own adjacency store and breadth-first walk, and compares every result
// ----------------------------------------------------------------------------
module tree_path_xor_pair_count_top_test;

   localparam int NODES      = tpx_pkg::MAX_NODES_DEFAULT;
   localparam int EDGE_SLOTS = 2 * NODES;
   localparam int STALL_MAX  = 2000000;
   localparam int SETTLE     = NODES + 100;
   localparam int CB         = tpx_pkg::COUNT_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [tpx_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [tpx_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [tpx_pkg::CSR_INDEX_BITS-1:0] csr_index = tpx_pkg::CSR_TARGET_XOR;
   logic [tpx_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   tree_path_xor_pair_count_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [9:0]  adj_to [EDGE_SLOTS];
   logic [31:0] adj_w [EDGE_SLOTS];
   int          adj_next [EDGE_SLOTS];
   int          node_first [NODES];
   int          adj_fill;
   logic [31:0] cfg_target;
   logic [10:0] cfg_nodes;
   bit          seen [NODES];
   int          walk_order [NODES];
   logic [31:0] path_xor [NODES];

   logic [CB-1:0] pending_counts[$];
   int  errors = 0;
   int  items_sent = 0;
   bit  quiet = 1'b0;
   int  stall_cycles = 0;
   int  rsp_hold = 0;

   function automatic void clear_adjacency();
      for (int i = 0; i < NODES; i++) node_first[i] = EDGE_SLOTS;
      adj_fill = 0;
   endfunction

   function automatic void link_half(int a, int b, logic [31:0] w);
      adj_to[adj_fill] = b[9:0];
      adj_w[adj_fill] = w;
      adj_next[adj_fill] = node_first[a];
      node_first[a] = adj_fill;
      adj_fill++;
   endfunction

   function automatic logic [CB-1:0] count_xor_pairs(int n);
      int front, back, v, p, u;
      logic [31:0] total;
      front = 0;
      back = 0;
      total = 0;
      if (n == 0) return '0;
      for (int i = 0; i < NODES; i++) seen[i] = 1'b0;
      walk_order[back++] = 0;
      seen[0] = 1'b1;
      path_xor[0] = '0;
      while (front < back) begin
         v = walk_order[front++];
         p = node_first[v];
         while (p < EDGE_SLOTS) begin
            u = adj_to[p];
            if (u < n && !seen[u] && back < n) begin
               seen[u] = 1'b1;
               path_xor[u] = path_xor[v] ^ adj_w[p];
               walk_order[back++] = u;
            end
            p = adj_next[p];
         end
      end
      for (int i = 0; i < back; i++)
         for (int j = i + 1; j < back; j++)
            if ((path_xor[walk_order[i]] ^ path_xor[walk_order[j]]) == cfg_target)
               total++;
      return total[CB-1:0];
   endfunction

   function automatic bit apply_edge(int a, int b, logic [31:0] w, bit last,
                                     output logic [CB-1:0] cnt);
      int n;
      n = (cfg_nodes > NODES) ? NODES : cfg_nodes;
      cnt = '0;
      if (a < n && b < n && adj_fill + 2 <= EDGE_SLOTS) begin
         link_half(a, b, w);
         link_half(b, a, w);
      end
      if (!last) return 1'b0;
      cnt = count_xor_pairs(n);
      clear_adjacency();
      return 1'b1;
   endfunction

   task automatic send_edge(int a, int b, logic [31:0] w, bit last,
                            bit fixed = 1'b0, logic [CB-1:0] fixed_cnt = '0);
      logic [CB-1:0] cnt;
      req_tdata <= {4'b0, w, b[9:0], a[9:0]};
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (apply_edge(a, b, w, last, cnt))
         pending_counts.push_back(fixed ? fixed_cnt : cnt);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [tpx_pkg::CSR_INDEX_BITS-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == tpx_pkg::CSR_TARGET_XOR) cfg_target = val;
      else cfg_nodes = val[10:0];
   endtask

   function automatic logic [31:0] pick_weight(bit wide);
      return wide ? $urandom() : $urandom_range(0, 3);
   endfunction

   // one tree over nodes 0..size-1, with some noise edges mixed in
   task automatic send_tree(int size, bit wide);
      int a, b, edges;
      edges = (size < 2) ? 1 : size - 1;
      for (int k = 1; k <= edges; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            a = $urandom_range(0, NODES - 1);
            b = $urandom_range(0, NODES - 1);
         end else if ($urandom_range(0, 19) == 0) begin
            a = $urandom_range(0, k);
            b = a;
         end else begin
            a = k;
            b = $urandom_range(0, k - 1);
         end
         if ($urandom_range(0, 1)) send_edge(a, b, pick_weight(wide), k == edges);
         else send_edge(b, a, pick_weight(wide), k == edges);
      end
   endtask

   typedef struct {
      int            a;
      int            b;
      logic [31:0]   w;
      bit            last;
      bit            fixed;
      logic [CB-1:0] cnt;
   } edge_row_type;

   edge_row_type directed_rows[] = '{
      '{0, 1, 32'h0, 1, 1, 1},
      '{0, 1, 32'hFFFF_FFFF, 1, 1, 0},
      '{2, 1, 32'h0, 1, 1, 0},
      '{1023, 0, 32'h0, 1, 1, 0},
      '{1023, 1023, 32'hFFFF_FFFF, 1, 1, 0},
      '{1, 1, 32'h0, 1, 1, 0},
      '{0, 0, 32'hFFFF_FFFF, 1, 1, 0},
      '{1, 0, 32'h0, 0, 0, 0},
      '{0, 1, 32'h5, 1, 0, 0},
      '{0, 1, 32'h0, 0, 0, 0},
      '{1, 0, 32'h0, 1, 0, 0},
      '{0, 1, 32'hA5A5_5A5A, 0, 0, 0},
      '{0, 1023, 32'h0, 1, 0, 0}
   };

   // response side stalls
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles > STALL_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_counts.size() == 0) begin
               $display("%0t: unexpected item, expected none actual %0d", $time,
                        rsp_tdata[CB-1:0]);
               errors++;
            end else begin
               if (rsp_tdata[CB-1:0] !== pending_counts[0]) begin
                  $display("%0t: pair_count expected %0d actual %0d", $time,
                           pending_counts[0], rsp_tdata[CB-1:0]);
                  errors++;
               end
               void'(pending_counts.pop_front());
            end
         end
      end
   end

   initial begin
      int n, trees, size;
      logic [31:0] nval;
      cfg_target = '0;
      cfg_nodes = tpx_pkg::NODE_COUNT_RESET;
      clear_adjacency();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_edge(directed_rows[i].a, directed_rows[i].b, directed_rows[i].w,
                   directed_rows[i].last, directed_rows[i].fixed, directed_rows[i].cnt);

      while (items_sent < 720) begin
         drain_results();
         case ($urandom_range(0, 9))
            0: nval = 0;
            1: nval = 1;
            2: nval = 2047;
            3: nval = NODES;
            4: nval = {$urandom_range(0, 2097151), 11'd3};
            default: nval = $urandom_range(3, 16);
         endcase
         write_reg(tpx_pkg::CSR_NODE_COUNT, nval);
         case ($urandom_range(0, 5))
            0: write_reg(tpx_pkg::CSR_TARGET_XOR, 32'h0);
            1: write_reg(tpx_pkg::CSR_TARGET_XOR, 32'hFFFF_FFFF);
            2: write_reg(tpx_pkg::CSR_TARGET_XOR, $urandom());
            default: write_reg(tpx_pkg::CSR_TARGET_XOR, $urandom_range(0, 3));
         endcase
         n = (cfg_nodes > NODES) ? NODES : cfg_nodes;
         trees = $urandom_range(1, 6);
         for (int t = 0; t < trees; t++) begin
            size = (n > 16) ? $urandom_range(2, 16) : n;
            send_tree(size, $urandom_range(0, 7) == 0);
         end
      end

      // one full-size tree that also overflows the edge store
      drain_results();
      write_reg(tpx_pkg::CSR_NODE_COUNT, NODES);
      write_reg(tpx_pkg::CSR_TARGET_XOR, $urandom_range(0, 7));
      for (int k = 1; k < NODES; k++) begin
         if (items_sent > 1500) quiet = 1'b1;
         send_edge(k, $urandom_range(0, k - 1), $urandom_range(0, 7), 1'b0);
      end
      quiet = 1'b1;
      send_edge(5, 6, 32'hFFFF_FFFF, 1'b0);
      send_edge(7, 8, 32'hFFFF_FFFF, 1'b0);
      send_edge(9, 10, 32'hFFFF_FFFF, 1'b1);
      drain_results();

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

/* tree_path_xor_pair_count_top.f */
hdl/tpx_pkg.sv
hdl/tpx_ram.sv
hdl/tpx_core.sv
hdl/tree_path_xor_pair_count_top.sv
verif/tree_path_xor_pair_count_top_test.sv
